// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks, disabled while the active-low reset is asserted
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif

`endif

// File: rtl/core/mcopt_pkg.sv
// ---------------------------------------------------------------------------
// mcopt_pkg
// shared constants and types of the multi-channel timer
// ---------------------------------------------------------------------------
`default_nettype none

package mcopt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SCAN_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int ID_W      = 4;
    localparam int SEC_W     = 8;
    localparam int USEC_W    = 20;
    localparam int TIME_W    = 64;
    localparam int PERIOD_W  = 38;
    localparam int USEC_NS_W = 30;

    localparam logic [9:0]  NS_PER_USEC = 10'd1000;
    localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef struct packed {
        logic                start;
        logic                stop;
        logic                tick;
        logic                shift;
        logic [TIME_W-1:0]   now;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   deadline;
        logic                periodic;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/core/mcopt_cell.sv
// ---------------------------------------------------------------------------
// mcopt_cell
// one timer slot: period, deadline, mode and armed flag, plus a pending
// expiry flag that moves down the chain during a scan
// ---------------------------------------------------------------------------
`default_nettype none

module mcopt_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_sel,
    input  wire mcopt_pkg::t_cell_ctl  i_ctl,
    input  wire logic                  i_pend,
    output logic                       o_pend
);

    logic                             r_armed;
    logic                             r_pend;
    logic                             r_periodic;
    logic [mcopt_pkg::PERIOD_W-1:0]   r_period;
    logic [mcopt_pkg::TIME_W-1:0]     r_deadline;
    logic                             hit;
    logic [mcopt_pkg::TIME_W-1:0]     n_rearm;

    assign hit     = r_armed && (r_deadline < i_ctl.now);
    assign n_rearm = i_ctl.now + mcopt_pkg::TIME_W'(r_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            priority if (i_ctl.start && i_sel) begin
                r_armed <= 1'b1;
            end else if (i_ctl.stop && i_sel) begin
                r_armed <= 1'b0;
            end else if (i_ctl.tick && hit && !r_periodic) begin
                r_armed <= 1'b0;
            end else begin
                r_armed <= r_armed;
            end
            priority if (i_ctl.tick) begin
                r_pend <= hit;
            end else if (i_ctl.shift) begin
                r_pend <= i_pend;
            end else begin
                r_pend <= r_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.start && i_sel) begin
            r_period   <= i_ctl.period;
            r_deadline <= i_ctl.deadline;
            r_periodic <= i_ctl.periodic;
        end else if (i_ctl.tick && hit && r_periodic) begin
            r_deadline <= n_rearm;
        end else begin
            r_deadline <= r_deadline;
        end
    end

    assign o_pend = r_pend;

endmodule

`default_nettype wire

// File: rtl/core/multi_channel_oneshot_periodic_timer.sv
// ---------------------------------------------------------------------------
// multi_channel_oneshot_periodic_timer
// bank of one-shot / periodic timer slots kept in a chain of slot cells
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    action, timer_id, seconds,
//                                           microseconds, repeat_mode, now
// output    out        o_valid / i_stall    kind, slot, last
//
// start: two period math stages (mul, sum), then deadline add and write.
// stop: goes straight to the ack state. both wait in the ack state while the output is stalled.
// tick: all cells compare in parallel when the tick is accepted, then the
// pending flags shift down the cell chain, one slot per cycle unless a pending
// slot at the head waits on a stalled output; the scan ends once none is pending.
// reset clears all armed flags and returns the block to idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multi_channel_oneshot_periodic_timer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_timer_id,
    input  wire logic [7:0]  i_seconds,
    input  wire logic [19:0] i_microseconds,
    input  wire logic        i_repeat_mode,
    input  wire logic [63:0] i_now,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [3:0]       o_slot,
    output logic             o_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_ACK  = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;

    logic [2:0]                          r_state, n_state;
    logic                                r_is_stop;
    logic [mcopt_pkg::ID_W-1:0]          r_id;
    logic [mcopt_pkg::SEC_W-1:0]         r_sec;
    logic [mcopt_pkg::USEC_W-1:0]        r_usec;
    logic                                r_rep;
    logic [mcopt_pkg::TIME_W-1:0]        r_now;
    logic [mcopt_pkg::USEC_NS_W-1:0]     r_usec_ns;
    logic [mcopt_pkg::PERIOD_W-1:0]      r_sec_ns;
    logic [mcopt_pkg::PERIOD_W-1:0]      r_period;
    logic [mcopt_pkg::SCAN_W-1:0]        r_scan_cnt;

    logic                                r_o_valid;
    logic                                r_o_kind;
    logic [3:0]                          r_o_slot;
    logic                                r_o_last;
    logic                                n_load;
    logic                                n_o_kind;
    logic [3:0]                          n_o_slot;
    logic                                n_o_last;

    logic                                accept;
    logic                                id_ok;
    logic                                out_free;
    logic                                any_pend;
    logic                                rest_pend;
    logic                                do_shift;
    logic [mcopt_pkg::NUM_SLOTS-1:0]     pend_vec;
    mcopt_pkg::t_cell_ctl                ctl;

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign id_ok    = (int'(i_timer_id) < mcopt_pkg::NUM_SLOTS);
    assign out_free = !r_o_valid || !i_stall;
    assign any_pend = |pend_vec;
    assign rest_pend = |(pend_vec >> 1);

    always_comb begin
        n_state  = r_state;
        n_load   = 1'b0;
        n_o_kind = mcopt_pkg::KIND_ACK;
        n_o_slot = r_id;
        n_o_last = 1'b1;
        do_shift = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_action == mcopt_pkg::ACT_START && id_ok) begin
                        n_state = ST_MUL;
                    end else if (i_action == mcopt_pkg::ACT_STOP && id_ok) begin
                        n_state = ST_ACK;
                    end else if (i_action == mcopt_pkg::ACT_TICK) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MUL: n_state = ST_SUM;
            ST_SUM: n_state = ST_ACK;
            ST_ACK: begin
                if (out_free) begin
                    n_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                n_o_kind = mcopt_pkg::KIND_EXPIRY;
                n_o_slot = 4'(r_scan_cnt);
                n_o_last = !rest_pend;
                priority if (!any_pend) begin
                    n_state = ST_IDLE;
                end else if (pend_vec[0]) begin
                    if (out_free) begin
                        n_load   = 1'b1;
                        do_shift = 1'b1;
                    end
                end else begin
                    do_shift = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_stop  <= (i_action == mcopt_pkg::ACT_STOP);
            r_id       <= i_timer_id;
            r_sec      <= i_seconds;
            r_usec     <= i_microseconds;
            r_rep      <= i_repeat_mode;
            r_now      <= i_now;
            r_scan_cnt <= '0;
        end else if (do_shift) begin
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (r_state == ST_MUL) begin
            r_usec_ns <= mcopt_pkg::USEC_NS_W'(r_usec)
                       * mcopt_pkg::USEC_NS_W'(mcopt_pkg::NS_PER_USEC);
            r_sec_ns  <= mcopt_pkg::PERIOD_W'(r_sec)
                       * mcopt_pkg::PERIOD_W'(mcopt_pkg::NS_PER_SEC);
        end
        if (r_state == ST_SUM) begin
            r_period <= mcopt_pkg::PERIOD_W'(r_usec_ns) + r_sec_ns;
        end
        if (n_load) begin
            r_o_kind <= n_o_kind;
            r_o_slot <= n_o_slot;
            r_o_last <= n_o_last;
        end
    end

    always_comb begin
        ctl.start    = (r_state == ST_ACK) && out_free && !r_is_stop;
        ctl.stop     = (r_state == ST_ACK) && out_free && r_is_stop;
        ctl.tick     = accept && (i_action == mcopt_pkg::ACT_TICK);
        ctl.shift    = do_shift;
        ctl.now      = i_now;
        ctl.period   = r_period;
        ctl.deadline = r_now + mcopt_pkg::TIME_W'(r_period);
        ctl.periodic = r_rep;
    end

    for (genvar i = 0; i < mcopt_pkg::NUM_SLOTS; i++) begin : g_cell
        logic sel;
        logic pend_in;
        assign sel = (int'(r_id) == i);
        if (i == mcopt_pkg::NUM_SLOTS - 1) begin : g_end
            assign pend_in = 1'b0;
        end else begin : g_mid
            assign pend_in = pend_vec[i+1];
        end
        mcopt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sel   (sel),
            .i_ctl   (ctl),
            .i_pend  (pend_in),
            .o_pend  (pend_vec[i])
        );
    end

    assign o_valid = r_o_valid;
    assign o_kind  = r_o_kind;
    assign o_slot  = r_o_slot;
    assign o_last  = r_o_last;

    // acknowledgements are always the only result of their transaction
    `ASSERT_CLK(a_ack_last, i_clk, i_rst_n, (o_valid && o_kind == mcopt_pkg::KIND_ACK) |-> o_last)
    // no expiry is left pending once the block is idle
    `ASSERT_NEVER(a_idle_pend, i_clk, i_rst_n, (r_state == ST_IDLE) && any_pend)
    // a scan with nothing pending closes in the next cycle
    `ASSERT_CLK(a_scan_end, i_clk, i_rst_n, (r_state == ST_SCAN && !any_pend) |=> (r_state == ST_IDLE))
    // the pending chain only moves while scanning
    `ASSERT_NEVER(a_shift_scan, i_clk, i_rst_n, do_shift && (r_state != ST_SCAN))

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// timer slot bank check: start, stop and tick transactions from a command
// queue, a behavioral slot bank predicting acknowledgements and expiries,
// and a monitor comparing each result field by field
// ----------------------------------------------------------------------------
module testbench;
    import mcopt_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         IDLE_PCT   = 37;
    localparam int         N_RANDOM   = 350;

    typedef struct packed {
        logic [1:0]        action;
        logic [ID_W-1:0]   id;
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
        logic              rep;
        logic [TIME_W-1:0] now;
        logic              hold;
    } t_timer_cmd;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] slot;
        logic            last;
    } t_timer_evt;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_action;
    logic [3:0]        i_timer_id;
    logic [7:0]        i_seconds;
    logic [19:0]       i_microseconds;
    logic              i_repeat_mode;
    logic [63:0]       i_now;
    logic              o_valid;
    logic              i_stall;
    logic              o_kind;
    logic [3:0]        o_slot;
    logic              o_last;

    t_timer_cmd        cmd_q[$];
    t_timer_evt        pending_events[$];
    t_timer_cmd        cur_cmd;
    t_timer_evt        want;
    logic              cmd_taken;
    logic              calm;

    logic [PERIOD_W-1:0] slot_period   [NUM_SLOTS];
    logic [TIME_W-1:0]   slot_deadline [NUM_SLOTS];
    logic                slot_periodic [NUM_SLOTS];
    logic                slot_armed    [NUM_SLOTS];

    int n_accepted  = 0;
    int n_acks      = 0;
    int n_expiries  = 0;
    int burst_len   = 0;
    int max_burst   = 0;
    int n_errors    = 0;

    multi_channel_oneshot_periodic_timer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_timer_id     (i_timer_id),
        .i_seconds      (i_seconds),
        .i_microseconds (i_microseconds),
        .i_repeat_mode  (i_repeat_mode),
        .i_now          (i_now),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_slot         (o_slot),
        .o_last         (o_last)
    );

    assign calm = (n_accepted >= 150) && (n_accepted < 230);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic void add_cmd(input logic [1:0] action, input int id, input int sec,
                                    input int usec, input logic rep,
                                    input logic [TIME_W-1:0] now, input logic hold);
        t_timer_cmd c;
        c.action = action;
        c.id     = id[ID_W-1:0];
        c.sec    = sec[SEC_W-1:0];
        c.usec   = usec[USEC_W-1:0];
        c.rep    = rep;
        c.now    = now;
        c.hold   = hold;
        cmd_q.push_back(c);
    endfunction

    // slot bank behavior for one accepted transaction
    task automatic advance_timer_bank(input logic [1:0] act, input logic [ID_W-1:0] id,
                                      input logic [SEC_W-1:0] sec,
                                      input logic [USEC_W-1:0] usec, input logic rep,
                                      input logic [TIME_W-1:0] now);
        logic [63:0]    p;
        logic [NUM_SLOTS-1:0] hit;
        int             n;
        int             k;
        int             s;
        t_timer_evt     e;
        hit = '0;
        n = 0;
        k = 0;
        case (act)
            ACT_START, ACT_STOP: begin
                if (int'(id) < NUM_SLOTS) begin
                    if (act == ACT_START) begin
                        p = 64'(usec) * 64'(NS_PER_USEC) + 64'(sec) * 64'(NS_PER_SEC);
                        slot_period[id]   = p[PERIOD_W-1:0];
                        slot_deadline[id] = now + 64'(p[PERIOD_W-1:0]);
                        slot_periodic[id] = rep;
                        slot_armed[id]    = 1'b1;
                    end else begin
                        slot_armed[id] = 1'b0;
                    end
                    e.kind = KIND_ACK;
                    e.slot = id;
                    e.last = 1'b1;
                    pending_events.push_back(e);
                end
            end
            ACT_TICK: begin
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (slot_armed[s] && slot_deadline[s] < now) begin
                        hit[s] = 1'b1;
                        n++;
                        if (slot_periodic[s])
                            slot_deadline[s] = now + 64'(slot_period[s]);
                        else
                            slot_armed[s] = 1'b0;
                    end
                end
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (hit[s]) begin
                        k++;
                        e.kind = KIND_EXPIRY;
                        e.slot = s[ID_W-1:0];
                        e.last = (k == n);
                        pending_events.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // input driver
    always @(negedge i_clk) begin
        cmd_taken <= 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || cmd_taken) begin
            if (cmd_q.size() > 0 && !(cmd_q[0].hold && pending_events.size() > 0)
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                cur_cmd = cmd_q.pop_front();
                i_valid        <= 1'b1;
                i_action       <= cur_cmd.action;
                i_timer_id     <= cur_cmd.id;
                i_seconds      <= cur_cmd.sec;
                i_microseconds <= cur_cmd.usec;
                i_repeat_mode  <= cur_cmd.rep;
                i_now          <= cur_cmd.now;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                advance_timer_bank(i_action, i_timer_id, i_seconds, i_microseconds,
                                   i_repeat_mode, i_now);
                n_accepted++;
                cmd_taken <= 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d slot %0d last %0d",
                                              o_kind, o_slot, o_last));
                end else begin
                    want = pending_events.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, wanted %0d", o_kind, want.kind));
                    if (o_slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, wanted %0d", o_slot, want.slot));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0d, wanted %0d", o_last, want.last));
                    if (want.kind == KIND_ACK) begin
                        n_acks++;
                    end else begin
                        n_expiries++;
                        burst_len++;
                        if (want.last) begin
                            if (burst_len > max_burst)
                                max_burst = burst_len;
                            burst_len = 0;
                        end
                    end
                end
            end
        end
    end

    initial begin
        logic [TIME_W-1:0] t_ns;
        int n_random;
        int episode;
        int nstart;
        int nticks;
        int k;
        int sec;
        int usec;
        logic [1:0] act;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_action       = ACT_START;
        i_timer_id     = '0;
        i_seconds      = '0;
        i_microseconds = '0;
        i_repeat_mode  = 1'b0;
        i_now          = '0;
        cmd_taken      = 1'b0;
        for (k = 0; k < NUM_SLOTS; k++) begin
            slot_period[k]   = '0;
            slot_deadline[k] = '0;
            slot_periodic[k] = 1'b0;
            slot_armed[k]    = 1'b0;
        end

        // directed
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, 64'd0, 1'b0);
        add_cmd(ACT_UNUSED, 9, 255, 1048575, 1'b1, '1, 1'b0);
        add_cmd(ACT_START, 0, 0, 0, 1'b0, 64'd100, 1'b0);
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, 64'd100, 1'b0);
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, 64'd101, 1'b0);
        add_cmd(ACT_START, 15, 255, 1048575, 1'b1, 64'd0, 1'b0);
        add_cmd(ACT_START, 3, 0, 5, 1'b1, 64'd1000, 1'b0);
        add_cmd(ACT_START, 3, 0, 1, 1'b0, 64'd1000, 1'b0);
        add_cmd(ACT_STOP, 7, 0, 0, 1'b0, 64'd0, 1'b0);
        add_cmd(ACT_START, 7, 0, 2, 1'b1, 64'd1000, 1'b0);
        add_cmd(ACT_STOP, 7, 0, 0, 1'b0, 64'd0, 1'b0);
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, 64'd10000, 1'b0);
        add_cmd(ACT_START, 5, 255, 0, 1'b1, '1, 1'b1);
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, 64'h8000_0000_0000_0000, 1'b0);
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, '1, 1'b0);
        add_cmd(ACT_STOP, 5, 0, 0, 1'b0, 64'd0, 1'b0);
        add_cmd(ACT_STOP, 15, 0, 0, 1'b0, 64'd0, 1'b0);
        add_cmd(ACT_STOP, 0, 0, 0, 1'b0, 64'd0, 1'b0);

        // random
        t_ns = '0;
        n_random = 0;
        episode = 0;
        while (n_random < N_RANDOM) begin
            episode++;
            if ($urandom_range(0, 99) < 75) begin
                nstart = ($urandom_range(0, 3) == 0) ? NUM_SLOTS : $urandom_range(1, 6);
                for (k = 0; k < nstart; k++) begin
                    sec  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : 0;
                    usec = ($urandom_range(0, 9) == 0) ? int'($urandom) : $urandom_range(0, 4);
                    add_cmd(ACT_START, (nstart == NUM_SLOTS) ? k : $urandom_range(0, 15),
                            sec, usec, 1'($urandom_range(0, 1)), t_ns,
                            (k == 0) && (episode % 10 == 0));
                    t_ns = t_ns + 64'($urandom_range(0, 50));
                    n_random++;
                end
                nticks = $urandom_range(1, 4);
                for (k = 0; k < nticks; k++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_cmd(ACT_STOP, $urandom_range(0, 15), 0, 0, 1'b0, t_ns, 1'b0);
                        n_random++;
                    end
                    t_ns = t_ns + 64'($urandom_range(0, 4000));
                    add_cmd(ACT_TICK, 0, 0, 0, 1'b0, t_ns, 1'b0);
                    n_random++;
                end
            end else begin
                act = 2'($urandom_range(0, 3));
                add_cmd(act, $urandom_range(0, 15), $urandom_range(0, 255), int'($urandom),
                        1'($urandom_range(0, 1)), {$urandom, $urandom}, 1'b0);
                if (act != ACT_UNUSED)
                    n_random++;
            end
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() > 0 || i_valid)
            @(posedge i_clk);
        while (pending_events.size() > 0)
            @(posedge i_clk);
        repeat (4 * NUM_SLOTS) @(posedge i_clk);

        $display("tb: %0d transactions accepted, %0d acknowledgements, %0d expiries",
                 n_accepted, n_acks, n_expiries);
        $display("tb: largest expiry burst from one tick: %0d slots", max_burst);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
